// ===== rtl/core/fs20ook_pkg.sv =====
// Shared constants and types of the frame encoder.
`timescale 1ns / 1ps

package fs20ook_pkg;

	// Frame bits in one frame: 12 zeros, start bit, 5 x (byte + parity), stop bit.
	localparam int unsigned FRAME_BITS = 59;
	localparam int unsigned IDX_W      = 6;

	localparam logic [IDX_W-1:0] FRAME_LEN = IDX_W'(FRAME_BITS);

	localparam logic [7:0] CHECKSUM_OFFSET_RESET = 8'd6;

	// Chip counts per frame bit: on chips, and last phase of the bit.
	localparam logic [2:0] ONE_ON     = 3'd3;
	localparam logic [2:0] ZERO_ON    = 3'd2;
	localparam logic [2:0] ONE_LAST   = 3'd5;
	localparam logic [2:0] ZERO_LAST  = 3'd3;

	// Position of the chip generator inside the frame.
	typedef struct packed {
		logic [IDX_W-1:0] bit_idx;
		logic [2:0]       phase;
	} gen_pos_t;

	// Packer result: new position and how many frame bits were used up.
	typedef struct packed {
		gen_pos_t   pos;
		logic [1:0] consumed;
	} gen_step_t;

endpackage

// ===== rtl/core/fs20ook_frame_encoder_unit.sv =====
// Top level of the remote-switch frame encoder with on/off chip packing.
//
//   channel   dir   handshake              payload
//   input     in    in_valid / in_stall    house_code[15:0], address[7:0], command[7:0]
//   config    in    cfg_wr_en              cfg_wr_data[7:0] (checksum offset)
//   output    out   out_valid / out_stall  chip_byte[7:0], last
//
// One word in gives 30 to 40 chip words out. After a word is taken the
// checksum adder sums the four payload bytes one byte at a time, S_BUILD
// forms the 59-bit frame, then the packer emits one chip word per cycle
// unless the output stalls. The input is stalled from acceptance until
// the last chip word enters the output register, so output stalls while
// the packer runs lengthen the frame. Reset clears the sequencer and the
// output valid and loads checksum offset 6.
`timescale 1ns / 1ps

module fs20_ook_frame_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] house_code,
	input  logic [7:0]  address,
	input  logic [7:0]  command,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  chip_byte,
	output logic        last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SUM,
		S_BUILD,
		S_RUN
	} state_t;

	state_t                           state_q;
	logic [7:0]                       offset_q;
	logic [7:0]                       hi_q;
	logic [7:0]                       lo_q;
	logic [7:0]                       addr_q;
	logic [7:0]                       cmd_q;
	logic [7:0]                       sum_q;
	logic [1:0]                       cnt_q;
	logic [fs20ook_pkg::FRAME_BITS-1:0] frame_q;
	fs20ook_pkg::gen_pos_t            pos_q;
	logic                             out_valid_q;
	logic [7:0]                       chip_byte_q;
	logic                             last_q;

	logic [7:0]             addend;
	logic [7:0]             pack_byte;
	fs20ook_pkg::gen_step_t pack_step;
	logic                   in_take;
	logic                   out_take;
	logic                   out_free;
	logic                   frame_done;

	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid & ~in_stall;
	assign out_take  = out_valid_q & ~out_stall;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign chip_byte = chip_byte_q;
	assign last      = last_q;

	// Operand select for the shared checksum adder: one byte per cycle.
	always_comb begin
		case (cnt_q)
			2'd0:    addend = hi_q;
			2'd1:    addend = lo_q;
			2'd2:    addend = addr_q;
			default: addend = cmd_q;
		endcase
	end

	// Next eight chips from the three frame bits at the head of the shifter.
	fs20ook_chip_pack u_pack (
		.frame_top (frame_q[fs20ook_pkg::FRAME_BITS-1 -: 3]),
		.pos       (pos_q),
		.chip_byte (pack_byte),
		.step      (pack_step)
	);

	// Padding chips past the stop bit are zero, so the word that reaches
	// the end of the frame is the last one.
	assign frame_done = (pack_step.pos.bit_idx == fs20ook_pkg::FRAME_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			offset_q    <= fs20ook_pkg::CHECKSUM_OFFSET_RESET;
			hi_q        <= '0;
			lo_q        <= '0;
			addr_q      <= '0;
			cmd_q       <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			frame_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			chip_byte_q <= '0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				offset_q <= cfg_wr_data;
			end
			// Drop the output word once the far side takes it; while running,
			// the sequencer refills the register instead.
			if (out_take && state_q != S_RUN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						hi_q    <= house_code[15:8];
						lo_q    <= house_code[7:0];
						addr_q  <= address;
						cmd_q   <= command;
						sum_q   <= offset_q;
						cnt_q   <= 2'd0;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					// Accumulate the four payload bytes modulo 256.
					sum_q <= sum_q + addend;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd3) begin
						state_q <= S_BUILD;
					end
				end
				S_BUILD: begin
					// Preamble, start bit, bytes with even parity, stop bit.
					frame_q <= {12'd0, 1'b1,
						hi_q, ^hi_q, lo_q, ^lo_q, addr_q, ^addr_q,
						cmd_q, ^cmd_q, sum_q, ^sum_q, 1'b0};
					pos_q   <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					// Advance one chip word whenever the output register frees up.
					if (out_free) begin
						out_valid_q <= 1'b1;
						chip_byte_q <= pack_byte;
						last_q      <= frame_done;
						pos_q       <= pack_step.pos;
						frame_q     <= frame_q << pack_step.consumed;
						if (frame_done) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/fs20ook_chip_pack.sv =====
// Packs the next eight on/off chips of the frame into one word.
`timescale 1ns / 1ps

module fs20ook_chip_pack (
	input  logic [2:0]              frame_top,
	input  fs20ook_pkg::gen_pos_t   pos,
	output logic [7:0]              chip_byte,
	output fs20ook_pkg::gen_step_t  step
);

	always_comb begin
		logic [fs20ook_pkg::IDX_W-1:0] idx;
		logic [2:0]                    ph;
		logic [1:0]                    k;
		logic                          b;
		logic [2:0]                    n_on;
		logic [2:0]                    n_last;
		idx       = pos.bit_idx;
		ph        = pos.phase;
		k         = 2'd0;
		chip_byte = 8'd0;
		for (int i = 0; i < 8; i++) begin
			// At most two frame bits complete inside eight chips.
			case (k)
				2'd0:    b = frame_top[2];
				2'd1:    b = frame_top[1];
				default: b = frame_top[0];
			endcase
			n_on   = b ? fs20ook_pkg::ONE_ON : fs20ook_pkg::ZERO_ON;
			n_last = b ? fs20ook_pkg::ONE_LAST : fs20ook_pkg::ZERO_LAST;
			if (idx < fs20ook_pkg::FRAME_LEN) begin
				chip_byte[3'(7 - i)] = (ph < n_on);
				if (ph == n_last) begin
					ph  = 3'd0;
					idx = idx + 1'b1;
					k   = k + 1'b1;
				end else begin
					ph = ph + 1'b1;
				end
			end
		end
		step.pos.bit_idx = idx;
		step.pos.phase   = ph;
		step.consumed    = k;
	end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the remote-switch frame encoder.
`timescale 1ns / 1ps

module testbench;

	// Slowest correct run: 314 frames of at most 40 words each, every word
	// waiting out a long stall, plus sender gaps; this bound is many times that.
	localparam int unsigned RUN_LIMIT  = 400000;
	localparam int unsigned DRAIN_WAIT = 60;
	localparam int unsigned CFG_SETTLE = 8;
	localparam int unsigned PER_PHASE  = 100;
	localparam int unsigned RETUNE_GAP = 25;

	typedef struct packed {
		logic [7:0] chips;
		logic       last;
	} chip_word_t;

	// One directed row: optional offset write, then one frame. n_words is the
	// frame length where it is obvious by hand, 0 where only the predictor knows.
	typedef struct {
		logic        wr_cfg;
		logic [7:0]  offset;
		logic [15:0] house;
		logic [7:0]  addr;
		logic [7:0]  cmd;
		int unsigned n_words;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] house_code = '0;
	logic [7:0]  address = '0;
	logic [7:0]  command = '0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  chip_byte;
	logic        last;

	chip_word_t  chip_words_due [$];
	int unsigned frame_len_due [$];
	logic [7:0]  offset_model = fs20ook_pkg::CHECKSUM_OFFSET_RESET;
	int unsigned send_gap_pct = 0;
	int unsigned out_hold_pct = 0;
	int unsigned cycle_count = 0;
	int unsigned frame_words = 0;
	logic        mismatch_seen = 1'b0;

	stim_row_t directed_rows [14] = '{
		// reset offset 6, empty frame: three 1 bits in all
		'{1'b0, 8'h00, 16'h0000, 8'h00, 8'h00, 31},
		'{1'b0, 8'h00, 16'hFFFF, 8'hFF, 8'hFF, 0},
		// all-zero frame: only the start bit is a 1
		'{1'b1, 8'h00, 16'h0000, 8'h00, 8'h00, 30},
		// checksum lands on 0xFF: densest frame
		'{1'b1, 8'h03, 16'hFFFF, 8'hFF, 8'hFF, 40},
		'{1'b0, 8'h00, 16'hFF00, 8'h00, 8'hFF, 0},
		'{1'b0, 8'h00, 16'h00FF, 8'hFF, 8'h00, 0},
		'{1'b1, 8'hFF, 16'h5555, 8'hAA, 8'h55, 0},
		'{1'b0, 8'h00, 16'hAAAA, 8'h55, 8'hAA, 0},
		'{1'b0, 8'h00, 16'h8001, 8'h80, 8'h01, 0},
		'{1'b0, 8'h00, 16'h0180, 8'h7F, 8'hFE, 0},
		// large offset: byte sum wraps past 256
		'{1'b1, 8'hF0, 16'h1234, 8'h56, 8'h78, 0},
		'{1'b0, 8'h00, 16'hFEDC, 8'hBA, 8'h98, 0},
		'{1'b1, 8'h06, 16'h0100, 8'h02, 8'h04, 0},
		'{1'b0, 8'h00, 16'h0000, 8'h00, 8'h01, 0}
	};

	fs20_ook_frame_encoder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.house_code (house_code),
		.address    (address),
		.command    (command),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.chip_byte  (chip_byte),
		.last       (last)
	);

	always #5ns clk = ~clk;

	// Build the 59-bit frame, expand each bit into on/off chips, pack them MSB
	// first and queue the resulting chip words; the final word carries last.
	function automatic void queue_frame_chips(input logic [15:0] house, input logic [7:0] addr,
			input logic [7:0] cmd);
		logic [7:0]                         hi;
		logic [7:0]                         lo;
		logic [7:0]                         sum;
		logic [fs20ook_pkg::FRAME_BITS-1:0] frame;
		logic [7:0]                         acc;
		int unsigned                        fill;
		int unsigned                        n_on;
		int unsigned                        i;
		int unsigned                        k;
		chip_word_t                         w;
		hi = house[15:8];
		lo = house[7:0];
		sum = offset_model + hi + lo + addr + cmd;
		// twelve 0 bits, the start bit, five bytes each with even parity, stop bit
		frame = {12'b0, 1'b1, hi, ^hi, lo, ^lo, addr, ^addr, cmd, ^cmd, sum, ^sum, 1'b0};
		acc = '0;
		fill = 0;
		for (i = 0; i < fs20ook_pkg::FRAME_BITS; i++) begin
			n_on = frame[fs20ook_pkg::FRAME_BITS-1-i] ? 3 : 2;
			for (k = 0; k < 2 * n_on; k++) begin
				acc[7-fill] = (k < n_on);
				fill++;
				if (fill == 8) begin
					w.chips = acc;
					w.last = 1'b0;
					chip_words_due.push_back(w);
					acc = '0;
					fill = 0;
				end
			end
		end
		// pad the tail with off chips
		if (fill != 0) begin
			w.chips = acc;
			w.last = 1'b0;
			chip_words_due.push_back(w);
		end
		w = chip_words_due.pop_back();
		w.last = 1'b1;
		chip_words_due.push_back(w);
	endfunction

	// Mostly random bytes, with the extremes showing up often.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return 8'($urandom);
			end
		endcase
	endfunction

	// Offer one command word, hold it until taken, then book its chip words.
	task automatic offer_frame(input logic [15:0] house, input logic [7:0] addr,
			input logic [7:0] cmd, input int unsigned n_words);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		house_code <= house;
		address <= addr;
		command <= cmd;
		do @(posedge clk); while (in_stall);
		queue_frame_chips(house, addr, cmd);
		frame_len_due.push_back(n_words);
	endtask

	// Drain the encoder, let it settle, then load a new checksum offset.
	task automatic write_offset(input logic [7:0] value);
		in_valid <= 1'b0;
		while (chip_words_due.size() != 0) @(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		offset_model = value;
	endtask

	// Output side: check each word taken, then pick the stall for the next cycle.
	always @(posedge clk) begin : watch_chips
		chip_word_t  due;
		int unsigned n_typed;
		if (out_valid && !out_stall) begin
			if (chip_words_due.size() == 0) begin
				$error("chip_byte: no word expected, got %h (last %b)", chip_byte, last);
				mismatch_seen = 1'b1;
			end else begin
				due = chip_words_due.pop_front();
				if (chip_byte !== due.chips) begin
					$error("chip_byte: expected %h, got %h", due.chips, chip_byte);
					mismatch_seen = 1'b1;
				end
				if (last !== due.last) begin
					$error("last: expected %b, got %b", due.last, last);
					mismatch_seen = 1'b1;
				end
			end
			frame_words = frame_words + 1;
			if (last === 1'b1) begin
				if (frame_len_due.size() != 0) begin
					n_typed = frame_len_due.pop_front();
					if (n_typed != 0 && n_typed != frame_words) begin
						$error("frame length: expected %0d, got %0d", n_typed, frame_words);
						mismatch_seen = 1'b1;
					end
				end
				frame_words = 0;
			end
		end
		out_stall <= ($urandom_range(0, 99) < out_hold_pct);
	end

	// Hard stop in case the encoder hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned ph;
		int unsigned j;
		int unsigned r;
		send_gap_pct = 27;
		out_hold_pct = 55;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames: field extremes, parity patterns, offset corners
		for (r = 0; r < $size(directed_rows); r++) begin
			if (directed_rows[r].wr_cfg) begin
				write_offset(directed_rows[r].offset);
			end
			offer_frame(directed_rows[r].house, directed_rows[r].addr,
				directed_rows[r].cmd, directed_rows[r].n_words);
		end

		// random frames in three phases (the last without gaps or stalls), offset retuned now and then
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_gap_pct = 27;
					out_hold_pct = 55;
				end
				1: begin
					send_gap_pct = 55;
					out_hold_pct = 27;
				end
				default: begin
					send_gap_pct = 0;
					out_hold_pct = 0;
				end
			endcase
			for (j = 0; j < PER_PHASE; j++) begin
				if (j % RETUNE_GAP == 0) begin
					write_offset(pick_byte());
				end
				offer_frame({pick_byte(), pick_byte()}, pick_byte(), pick_byte(), 0);
			end
		end

		in_valid <= 1'b0;
		while (chip_words_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (!mismatch_seen && chip_words_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
